// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers included by sliding_window_max_sum
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/swms_pkg.sv =====
// ----------------------------------------------------------------------------
// swms_pkg
// Shared constants, types and helpers of the sliding window max sum block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swms_pkg;

  // ring depth, must be a power of two so the slot pointer wraps naturally
  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
  localparam int LEN_W       = 7;
  localparam int SUM_W       = SAMPLE_BITS + ADDR_W + 1;
  localparam int OUT_W       = 22;
  localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]       sum_t;

  // per-sample control handed from the address stage to the accumulate stage
  typedef struct packed {
    logic use_old;     // window already full before this sample
    logic first_full;  // window not yet full before this sample
    logic full_after;  // window full after this sample
    logic too_short;   // sequence still shorter than the window
    logic last;        // final sample of the sequence
  } s1_ctl_t;

  // clamp the programmed length into 1..MAX_WINDOW
  function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [CNT_W-1:0] res;
    if (len == '0) begin
      res = CNT_W'(1);
    end else if (int'(len) > MAX_WINDOW) begin
      res = CNT_W'(MAX_WINDOW);
    end else begin
      res = CNT_W'(len);
    end
    return res;
  endfunction

endpackage

// ===== design/swms_ring.sv =====
// ----------------------------------------------------------------------------
// swms_ring
// Sample ring memory, one write and one registered read per cycle while en_i is high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swms_ring (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [swms_pkg::ADDR_W-1:0] wr_addr_i,
  input  swms_pkg::sample_t      wr_data_i,
  input  logic [swms_pkg::ADDR_W-1:0] rd_addr_i,
  output swms_pkg::sample_t      rd_data_o
);
  import swms_pkg::*;

  sample_t mem [MAX_WINDOW];
  sample_t rd_data_q;

  // read-first: a read of the slot being written returns the old sample
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd_data_q      <= mem[rd_addr_i];
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/swms_acc.sv =====
// ----------------------------------------------------------------------------
// swms_acc
// Running window sum and best sum, result of each sequence
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swms_acc (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clear_i,
  input  logic                 step_i,
  input  swms_pkg::s1_ctl_t    ctl_i,
  input  swms_pkg::sample_t    sample_i,
  input  swms_pkg::sample_t    old_i,
  output logic                 res_valid_o,
  output logic [swms_pkg::OUT_W-1:0] res_sum_o,
  output logic                 res_short_o
);
  import swms_pkg::*;

  sum_t window_total_q, window_total_d;
  sum_t best_total_q, best_total_d;
  sum_t new_total;
  sum_t best_upd;

  // add the incoming sample, drop the one leaving the window
  always_comb begin
    new_total = window_total_q + SUM_W'(sample_i);
    if (ctl_i.use_old) begin
      new_total = new_total - SUM_W'(old_i);
    end
    best_upd = best_total_q;
    if (ctl_i.full_after && (ctl_i.first_full || (new_total > best_total_q))) begin
      best_upd = new_total;
    end
  end

  // next state, cleared at sequence end and on clear_i
  always_comb begin
    window_total_d = window_total_q;
    best_total_d   = best_total_q;
    if (clear_i) begin
      window_total_d = '0;
      best_total_d   = '0;
    end else if (step_i) begin
      if (ctl_i.last) begin
        window_total_d = '0;
        best_total_d   = '0;
      end else begin
        window_total_d = new_total;
        best_total_d   = best_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_total_q <= '0;
      best_total_q   <= '0;
    end else begin
      window_total_q <= window_total_d;
      best_total_q   <= best_total_d;
    end
  end

  // result of the final sample
  assign res_valid_o = step_i && ctl_i.last;
  assign res_short_o = ctl_i.too_short;
  assign res_sum_o   = ctl_i.too_short ? '1 : best_upd[OUT_W-1:0];

endmodule

// ===== design/sliding_window_max_sum.sv =====
// ----------------------------------------------------------------------------
// sliding_window_max_sum
// Largest sum over any window_len consecutive samples of a sequence
// ----------------------------------------------------------------------------
// The block takes one signed sample per cycle and gives one result per
// sequence. The sample marked with tlast passes the accumulate stage
// registers, and its result then goes into the output register unless an
// earlier result still waits there. When not stalled, the rate is
// one sample per clock: the ring memory takes one write and one
// read each cycle, and the accumulate stage does one add, one subtract and
// one compare per sample. Input stalls only while a finished result waits
// at the output and the next sequence end has already reached the
// accumulate stage. Writing window_len clears the sequence state; write it
// only while no sequence is in flight. Ring entries need no clearing.
`timescale 1ns / 1ps

module sliding_window_max_sum (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [swms_pkg::LEN_W-1:0]    cfg_data_i,
  // sample stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [swms_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,  // [15:0] sample
  input  logic                          s_axis_tlast_i,
  // result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [swms_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o, // [21:0] max_sum
  output logic                          m_axis_tuser_o   // [0] too_short
);
  import swms_pkg::*;
  `include "assert_macros.svh"

  logic [LEN_W-1:0]  window_len_q;
  logic [CNT_W-1:0]  seen_count_q, seen_count_d;
  logic [ADDR_W-1:0] write_slot_q, write_slot_d;
  logic [CNT_W-1:0]  len_eff;
  logic [CNT_W-1:0]  seen_after;
  logic [ADDR_W-1:0] old_slot;
  logic              cfg_wr;
  logic              accept;
  logic              stall;
  sample_t           in_sample;
  s1_ctl_t           s0_ctl;

  logic              s1_valid_q;
  s1_ctl_t           s1_ctl_q;
  sample_t           s1_sample_q;
  sample_t           old_sample;

  logic              res_valid;
  logic [OUT_W-1:0]  res_sum;
  logic              res_short;
  logic              out_valid_q;
  logic [OUT_W-1:0]  out_sum_q;
  logic              out_short_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // hold the input while a second sequence end would overrun the output
  assign stall           = s1_valid_q && s1_ctl_q.last && out_valid_q && !m_axis_tready_i;
  assign s_axis_tready_o = !stall;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_sample       = s_axis_tdata_i[SAMPLE_BITS-1:0];

  // address stage: ring slots and window fill flags
  always_comb begin
    len_eff    = eff_len(window_len_q);
    seen_after = (int'(seen_count_q) < MAX_WINDOW) ? seen_count_q + CNT_W'(1)
                                                   : seen_count_q;
    old_slot   = ADDR_W'(CNT_W'(write_slot_q) - len_eff);
    s0_ctl.use_old    = seen_count_q >= len_eff;
    s0_ctl.first_full = seen_count_q < len_eff;
    s0_ctl.full_after = seen_after >= len_eff;
    s0_ctl.too_short  = seen_after < len_eff;
    s0_ctl.last       = s_axis_tlast_i;
  end

  always_comb begin
    seen_count_d = seen_count_q;
    write_slot_d = write_slot_q;
    if (cfg_wr) begin
      seen_count_d = '0;
      write_slot_d = '0;
    end else if (accept) begin
      if (s_axis_tlast_i) begin
        seen_count_d = '0;
        write_slot_d = '0;
      end else begin
        seen_count_d = seen_after;
        write_slot_d = write_slot_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= LEN_W'(1);
      seen_count_q <= '0;
      write_slot_q <= '0;
    end else begin
      if (cfg_wr) begin
        window_len_q <= cfg_data_i;
      end
      seen_count_q <= seen_count_d;
      write_slot_q <= write_slot_d;
    end
  end

  // sample ring
  swms_ring u_ring (
    .clk_i     (clk_i),
    .en_i      (accept),
    .wr_addr_i (write_slot_q),
    .wr_data_i (in_sample),
    .rd_addr_i (old_slot),
    .rd_data_o (old_sample)
  );

  // accumulate stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!stall) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ctl_q    <= s0_ctl;
      s1_sample_q <= in_sample;
    end
  end

  swms_acc u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (cfg_wr),
    .step_i      (s1_valid_q && !stall),
    .ctl_i       (s1_ctl_q),
    .sample_i    (s1_sample_q),
    .old_i       (old_sample),
    .res_valid_o (res_valid),
    .res_sum_o   (res_sum),
    .res_short_o (res_short)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_sum_q   <= res_sum;
      out_short_q <= res_short;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_sum_q);
  assign m_axis_tuser_o  = out_short_q;

  // checks
  `ASSERT_ALWAYS(a_short_is_minus_one,
    !(m_axis_tvalid_o && m_axis_tuser_o) || (m_axis_tdata_o[OUT_W-1:0] == '1),
    "too_short result must carry -1")
  `ASSERT_ALWAYS(a_stall_cause,
    s_axis_tready_o || (s1_valid_q && s1_ctl_q.last && out_valid_q),
    "input stalled without a pending sequence end")
  `ASSERT_ALWAYS(a_count_bound, int'(seen_count_q) <= MAX_WINDOW,
    "sample count above ring depth")
  `ASSERT_NEXT(a_result_kept, out_valid_q && !m_axis_tready_i,
    out_valid_q && $stable(out_sum_q), "waiting result overwritten")

endmodule
